/* rtl/infix_to_postfix_converter_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter checker
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ITP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// next-cycle implication, disabled in reset
`define ITP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

/* rtl/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg
// Types, token codes and the precedence function of the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    // fixed field widths
    localparam int KIND_W   = 4;
    localparam int OKIND_W  = 3;
    localparam int VAL_W    = 32;
    localparam int ERR_W    = 2;
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // default parameter values
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // input token kinds
    localparam logic [KIND_W-1:0] K_NUM   = 4'd0;
    localparam logic [KIND_W-1:0] K_PLUS  = 4'd1;
    localparam logic [KIND_W-1:0] K_POW   = 4'd5;
    localparam logic [KIND_W-1:0] K_OPEN  = 4'd6;
    localparam logic [KIND_W-1:0] K_CLOSE = 4'd7;
    localparam logic [KIND_W-1:0] K_END   = 4'd8;

    // stack entry / output kinds
    localparam logic [OP_W-1:0] OP_NUM   = 3'd0;
    localparam logic [OP_W-1:0] OP_TIMES = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd4;
    localparam logic [OP_W-1:0] OP_POW   = 3'd5;
    localparam logic [OP_W-1:0] OP_OPEN  = 3'd6;
    localparam logic [OP_W-1:0] OUT_END  = 3'd6;

    // end-marker error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

    // register word index
    localparam logic REG_IMUL_IDX = 1'b0;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [VAL_W-1:0]  number_value;
    } t_in_word;

    typedef struct packed {
        logic [OKIND_W-1:0] out_kind;
        logic [VAL_W-1:0]   out_value;
        logic               out_last;
        logic [ERR_W-1:0]   out_error;
    } t_out_word;

    // shift command for the stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

    // ^ binds tightest, then * and /, then + and -
    function automatic logic [1:0] op_prec(input logic [OP_W-1:0] op);
        logic [1:0] p;
        p = 2'd1;
        if (op == OP_POW) begin
            p = 2'd3;
        end else if (op == OP_TIMES || op == OP_DIV) begin
            p = 2'd2;
        end
        return p;
    endfunction

endpackage

/* rtl/itp_cell.sv */
// ----------------------------------------------------------------------------
// itp_cell
// One entry of the shifting operator stack: takes its upper neighbor on a
// push, its lower neighbor on a pop, else holds.
// ----------------------------------------------------------------------------
module itp_cell import itp_pkg::*; (
    input  logic            i_clk,
    input  t_stk_cmd        i_cmd,
    input  logic [OP_W-1:0] i_from_up,
    input  logic [OP_W-1:0] i_from_down,
    output logic [OP_W-1:0] o_entry
);

    logic [OP_W-1:0] r_entry;
    logic [OP_W-1:0] n_entry;

    // shift select
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.push) begin
            n_entry = i_from_up;
        end else if (i_cmd.pop) begin
            n_entry = i_from_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

/* rtl/itp_stack.sv */
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack as a chain of cells; cell 0 is the top of stack.
// ----------------------------------------------------------------------------
module itp_stack import itp_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic            i_clk,
    input  t_stk_cmd        i_cmd,
    input  logic [OP_W-1:0] i_push_op,
    output logic [OP_W-1:0] o_top,
    output logic [OP_W-1:0] o_second
);

    logic [OP_W-1:0] w_ent [STACK_DEPTH];

    // cell chain
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [OP_W-1:0] w_up;
        logic [OP_W-1:0] w_down;
        if (g == 0) begin : g_first
            assign w_up = i_push_op;
        end else begin : g_mid_up
            assign w_up = w_ent[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_down = w_ent[g];
        end else begin : g_mid_down
            assign w_down = w_ent[g+1];
        end
        itp_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (i_cmd),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_entry     (w_ent[g])
        );
    end

    assign o_top    = w_ent[0];
    assign o_second = w_ent[1];

endmodule

/* rtl/infix_to_postfix_converter_top.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: tokens in, postfix tokens out.
// Each postfix word is registered before it leaves; the input stalls while
// the sequencer is busy, so a token is fully handled (operator pops, dropped
// '(', end marker) before the next is taken; output stalls hold the flow.
// Reset (sync, active low): stack empty, no error, implicit * enabled.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top import itp_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // token input
    input  logic              i_in_valid,
    input  t_in_word          i_in_data,
    output logic              o_in_stall,
    // postfix output
    output logic              o_out_valid,
    output t_out_word         o_out_data,
    input  logic              i_out_stall,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_NUM      = 7'b0000010,
        ST_PLACE    = 7'b0000100,
        ST_PUSHOPEN = 7'b0001000,
        ST_CLOSE    = 7'b0010000,
        ST_FLUSH    = 7'b0100000,
        ST_MARK     = 7'b1000000
    } t_state;

    t_state          r_st, n_st;
    logic [OP_W-1:0] r_op, n_op;
    logic            r_then_open, n_then_open;
    logic [VW-1:0]   r_val, n_val;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_aft, n_aft;
    logic [ERR_W-1:0] r_err, n_err;
    logic            r_imul, n_imul;
    logic            r_oval, n_oval;
    t_out_word       r_out, n_out;

    t_stk_cmd        s_cmd;
    logic [OP_W-1:0] s_push_op;
    logic [OP_W-1:0] w_top, w_second;
    logic            w_out_free, w_in_acc, w_full, w_top_pop, w_sec_pop;
    logic            w_cfg_wr;

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_cmd     (s_cmd),
        .i_push_op (s_push_op),
        .o_top     (w_top),
        .o_second  (w_second)
    );

    // handshake and stack status
    assign o_in_stall = (r_st != ST_IDLE);
    assign w_in_acc   = i_in_valid && (r_st == ST_IDLE);
    assign w_out_free = !r_oval || !i_out_stall;
    assign w_full     = (r_cnt >= CW'(STACK_DEPTH));
    assign w_top_pop  = (r_cnt != '0) && (w_top != OP_OPEN) &&
                        (op_prec(w_top) >= op_prec(r_op));
    assign w_sec_pop  = (r_cnt > CW'(1)) && (w_second != OP_OPEN) &&
                        (op_prec(w_second) >= op_prec(r_op));

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_IMUL_IDX);
    assign prdata   = (paddr[ADDR_W-1] == REG_IMUL_IDX) ? {{(DATA_W-1){1'b0}}, r_imul} : '0;
    assign n_imul   = w_cfg_wr ? pwdata[0] : r_imul;

    // sequencer
    always_comb begin
        n_st        = r_st;
        n_op        = r_op;
        n_then_open = r_then_open;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_aft       = r_aft;
        n_err       = r_err;
        n_oval      = r_oval && i_out_stall;
        n_out       = r_out;
        s_cmd       = '0;
        s_push_op   = r_op;

        case (r_st)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_val = i_in_data.number_value[VW-1:0];
                    case (i_in_data.token_kind) inside
                        K_NUM: begin
                            n_st  = ST_NUM;
                            n_aft = 1'b1;
                        end
                        [K_PLUS:K_POW]: begin
                            n_op        = i_in_data.token_kind[OP_W-1:0];
                            n_then_open = 1'b0;
                            n_st        = ST_PLACE;
                            n_aft       = 1'b0;
                        end
                        K_OPEN: begin
                            n_aft = 1'b0;
                            if (r_imul && r_aft) begin
                                n_op        = OP_TIMES;
                                n_then_open = 1'b1;
                                n_st        = ST_PLACE;
                            end else begin
                                n_st = ST_PUSHOPEN;
                            end
                        end
                        K_CLOSE: begin
                            n_st  = ST_CLOSE;
                            n_aft = 1'b1;
                        end
                        K_END: begin
                            n_st  = ST_FLUSH;
                            n_aft = 1'b0;
                        end
                        default: begin
                            n_st = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_NUM: begin
                if (w_out_free) begin
                    n_oval = 1'b1;
                    n_out  = '{OP_NUM, VAL_W'(r_val), 1'b1, ERR_NONE};
                    n_st   = ST_IDLE;
                end
            end

            // pop higher or equal precedence, then push the operator (overflow error if full)
            ST_PLACE: begin
                if (w_top_pop) begin
                    if (w_out_free) begin
                        n_oval    = 1'b1;
                        n_out     = '{w_top, '0, !w_sec_pop, ERR_NONE};
                        s_cmd.pop = 1'b1;
                        n_cnt     = r_cnt - CW'(1);
                    end
                end else begin
                    if (w_full) begin
                        if (r_err == ERR_NONE) n_err = ERR_OVERFLOW;
                    end else begin
                        s_cmd.push = 1'b1;
                        n_cnt      = r_cnt + CW'(1);
                    end
                    n_st = r_then_open ? ST_PUSHOPEN : ST_IDLE;
                end
            end

            ST_PUSHOPEN: begin
                s_push_op = OP_OPEN;
                if (w_full) begin
                    if (r_err == ERR_NONE) n_err = ERR_OVERFLOW;
                end else begin
                    s_cmd.push = 1'b1;
                    n_cnt      = r_cnt + CW'(1);
                end
                n_st = ST_IDLE;
            end

            // pop down to the matching open parenthesis
            ST_CLOSE: begin
                if (r_cnt == '0) begin
                    if (r_err == ERR_NONE) n_err = ERR_UNMATCHED;
                    n_st = ST_IDLE;
                end else if (w_top == OP_OPEN) begin
                    s_cmd.pop = 1'b1;
                    n_cnt     = r_cnt - CW'(1);
                    n_st      = ST_IDLE;
                end else if (w_out_free) begin
                    n_oval    = 1'b1;
                    n_out     = '{w_top, '0,
                                  (r_cnt == CW'(1)) || (w_second == OP_OPEN), ERR_NONE};
                    s_cmd.pop = 1'b1;
                    n_cnt     = r_cnt - CW'(1);
                end
            end

            // drain the stack, dropping open parentheses
            ST_FLUSH: begin
                if (r_cnt == '0) begin
                    n_st = ST_MARK;
                end else if (w_top == OP_OPEN) begin
                    s_cmd.pop = 1'b1;
                    n_cnt     = r_cnt - CW'(1);
                end else if (w_out_free) begin
                    n_oval    = 1'b1;
                    n_out     = '{w_top, '0, 1'b0, ERR_NONE};
                    s_cmd.pop = 1'b1;
                    n_cnt     = r_cnt - CW'(1);
                end
            end

            ST_MARK: begin
                if (w_out_free) begin
                    n_oval = 1'b1;
                    n_out  = '{OUT_END, '0, 1'b1, r_err};
                    n_err  = ERR_NONE;
                    n_st   = ST_IDLE;
                end
            end

            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_cnt  <= '0;
            r_aft  <= 1'b0;
            r_err  <= ERR_NONE;
            r_imul <= 1'b1;
            r_oval <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_aft  <= n_aft;
            r_err  <= n_err;
            r_imul <= n_imul;
            r_oval <= n_oval;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_then_open <= n_then_open;
        r_val       <= n_val;
        r_out       <= n_out;
    end

    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

endmodule

/* rtl/itp_checker.sv */
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks of the infix-to-postfix converter, bound to the top.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_top_assert.svh"

module itp_checker import itp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_word  i_in_data,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_word o_out_data,
    input logic      i_out_stall
);

    // error code only rides on the end marker
    `ITP_ASSERT_IMP(a_err_on_end_only, i_clk, i_rst_n,
        o_out_valid && (o_out_data.out_kind != OUT_END), o_out_data.out_error == ERR_NONE)

    // end marker and number always close their word's results
    `ITP_ASSERT_IMP(a_end_num_last, i_clk, i_rst_n,
        o_out_valid && (o_out_data.out_kind == OUT_END || o_out_data.out_kind == OP_NUM),
        o_out_data.out_last)

    // a meaningful token stalls the input side in the cycle after it is accepted
    `ITP_ASSERT_NXT(a_busy_after_token, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_in_data.token_kind <= K_END), o_in_stall)

    // a stalled word holds
    `ITP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: infix-to-postfix converter testbench
// Streams token words into the converter and checks every postfix word it
// produces against a shunting-yard predictor kept inside the bench. The run
// covers directed corner cases, then random well-formed, broken and noise
// sentences, over four idling settings. Implicit * is toggled between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import itp_pkg::*;

    localparam int STACK_DEPTH  = DEF_STACK_DEPTH;
    localparam int DRAIN_CYCLES = 2 * (STACK_DEPTH + 2) + 10;
    localparam int HOLD_CYCLES  = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NEST_MAX     = 4;
    localparam int PHASE_ITEMS  = 60;
    localparam int PRINT_MAX    = 50;

    // input kinds the package does not name
    localparam logic [KIND_W-1:0] TK_MINUS = 4'd2;
    localparam logic [KIND_W-1:0] TK_TIMES = 4'd3;
    localparam logic [KIND_W-1:0] TK_DIV   = 4'd4;
    localparam logic [KIND_W-1:0] TK_LAST  = 4'd15;  // highest ignored kind

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_word          i_in_data   = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out_word         o_out_data;
    logic              i_out_stall = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    infix_to_postfix_converter_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // pending token words and expected postfix words
    t_in_word  token_q[$];
    t_out_word postfix_q[$];

    // predictor state
    logic [OP_W-1:0]  op_stk [STACK_DEPTH];
    int               stk_cnt    = 0;
    bit               after_opnd = 1'b0;
    logic [ERR_W-1:0] err_held   = ERR_NONE;
    bit               imul_en    = 1'b1;
    int               step_n;

    // run control and statistics
    bit [31:0] cyc         = '0;
    int        send_pct    = 0;
    int        stall_pct   = 0;
    bit        hold_req    = 1'b0;
    bit        hold_done   = 1'b0;
    int        hold_left   = 0;
    int        stim_items  = 0;
    int        tokens_in   = 0;
    int        words_seen  = 0;
    int        end_words   = 0;
    int        ovf_ends    = 0;
    int        unm_ends    = 0;
    int        mismatches  = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int op_rank(input logic [OP_W-1:0] op);
        if (op == OP_POW) return 3;
        if (op == OP_TIMES || op == OP_DIV) return 2;
        return 1;
    endfunction

    task automatic add_word(input logic [OKIND_W-1:0] kind, input logic [VAL_W-1:0] value,
                            input logic [ERR_W-1:0] err);
        t_out_word w;
        w.out_kind  = kind;
        w.out_value = value;
        w.out_last  = 1'b0;
        w.out_error = err;
        postfix_q.push_back(w);
        step_n++;
    endtask

    task automatic stack_push(input logic [OP_W-1:0] op);
        if (stk_cnt >= STACK_DEPTH) begin
            // full stack drops the entry; first error wins
            if (err_held == ERR_NONE) err_held = ERR_OVERFLOW;
        end else begin
            op_stk[stk_cnt] = op;
            stk_cnt++;
        end
    endtask

    // pop everything of equal or higher rank (left assoc), stop at '('
    task automatic place_op(input logic [OP_W-1:0] op);
        int rank;
        rank = op_rank(op);
        while (stk_cnt > 0 && op_stk[stk_cnt-1] != OP_OPEN &&
               op_rank(op_stk[stk_cnt-1]) >= rank) begin
            add_word(op_stk[stk_cnt-1], '0, ERR_NONE);
            stk_cnt--;
        end
        stack_push(op);
    endtask

    task automatic convert_token(input t_in_word tok);
        logic [OP_W-1:0] top;
        bit              found;
        t_out_word       w;
        step_n = 0;
        found  = 1'b0;
        case (tok.token_kind)
            K_NUM: begin
                add_word(OP_NUM, tok.number_value, ERR_NONE);
                after_opnd = 1'b1;
            end
            K_PLUS, TK_MINUS, TK_TIMES, TK_DIV, K_POW: begin
                place_op(OP_W'(tok.token_kind));
                after_opnd = 1'b0;
            end
            K_OPEN: begin
                if (imul_en && after_opnd) place_op(OP_TIMES);
                stack_push(OP_OPEN);
                after_opnd = 1'b0;
            end
            K_CLOSE: begin
                while (stk_cnt > 0 && !found) begin
                    top = op_stk[stk_cnt-1];
                    stk_cnt--;
                    if (top == OP_OPEN) found = 1'b1;
                    else add_word(top, '0, ERR_NONE);
                end
                if (!found && err_held == ERR_NONE) err_held = ERR_UNMATCHED;
                after_opnd = 1'b1;
            end
            K_END: begin
                // flush, unclosed '(' vanish silently
                while (stk_cnt > 0) begin
                    top = op_stk[stk_cnt-1];
                    stk_cnt--;
                    if (top != OP_OPEN) add_word(top, '0, ERR_NONE);
                end
                add_word(OUT_END, '0, err_held);
                err_held   = ERR_NONE;
                after_opnd = 1'b0;
            end
            default: ;  // unused kinds are ignored
        endcase
        // mark the newest expected word as the last of this token
        if (step_n > 0) begin
            w = postfix_q[postfix_q.size() - 1];
            w.out_last = 1'b1;
            postfix_q[postfix_q.size() - 1] = w;
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic bit take_gap(input int pct);
        // every fourth window of cyc (cyc[7:6] == 0) runs with no gaps at all
        return (cyc[7:6] != 2'b00) && ($urandom_range(99) < pct);
    endfunction

    task automatic add_tok(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value);
        t_in_word tok;
        tok.token_kind   = kind;
        tok.number_value = value;
        token_q.push_back(tok);
        if (kind <= K_END) stim_items++;
    endtask

    task automatic add_number();
        logic [VAL_W-1:0] v;
        case ($urandom_range(7))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom();
        endcase
        add_tok(K_NUM, v);
    endtask

    task automatic add_op();
        add_tok(KIND_W'($urandom_range(K_PLUS, K_POW)), $urandom());
    endtask

    task automatic gen_operand(input int lvl);
        int pick;
        pick = $urandom_range(9);
        if (lvl < NEST_MAX && pick < 3) begin
            if (pick == 0) add_number();          // operand then '('
            add_tok(K_OPEN, $urandom());
            gen_expr(lvl + 1);
            add_tok(K_CLOSE, $urandom());
            if (pick == 1) begin                  // ')' then '('
                add_tok(K_OPEN, $urandom());
                add_number();
                add_tok(K_CLOSE, $urandom());
            end
        end else begin
            add_number();
        end
    endtask

    task automatic gen_expr(input int lvl);
        int terms;
        terms = $urandom_range(1, 4);
        gen_operand(lvl);
        for (int i = 1; i < terms; i++) begin
            add_op();
            gen_operand(lvl);
        end
    endtask

    // nest close to or past the stack depth
    task automatic add_deep_nest();
        int depth;
        int shut;
        depth = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4);
        shut  = $urandom_range(depth);
        for (int i = 0; i < depth; i++) add_tok(K_OPEN, $urandom());
        add_number();
        for (int i = 0; i < shut; i++) begin
            add_op();
            add_number();
            add_tok(K_CLOSE, $urandom());
        end
        add_tok(K_END, $urandom());
    endtask

    task automatic add_sentence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            if ($urandom_range(9) == 0) add_op();  // operator at the very start
            gen_expr(0);
            add_tok(K_END, $urandom());
        end else if (pick < 80) begin
            add_deep_nest();
        end else if (pick < 90) begin
            // broken: stray token in the middle
            gen_expr(0);
            case ($urandom_range(2))
                0:       add_tok(K_CLOSE, $urandom());
                1:       add_tok(K_OPEN, $urandom());
                default: add_op();
            endcase
            gen_expr(0);
            add_tok(K_END, $urandom());
        end else begin
            // noise, ignored kinds included
            repeat ($urandom_range(1, 5)) add_tok(KIND_W'($urandom_range(TK_LAST)), $urandom());
        end
    endtask

    // wait until all words are in and all results out, then let the block settle
    task automatic wait_drained();
        do @(posedge i_clk);
        while (token_q.size() != 0 || i_in_valid || postfix_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input int idx, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_MAX) $display("MISMATCH cycle %0d: %s", cyc, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s got %0h expected %0h",
                                      words_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // sequence: directed corners, then four random phases
    // ------------------------------------------------------------------------
    initial begin
        int  phase_send [4];
        int  phase_stall[4];
        bit  phase_imul [4];
        int  goal;
        phase_send  = '{0, 72, 0, 30};
        phase_stall = '{0, 0, 72, 30};
        phase_imul  = '{1'b0, 1'b1, 1'b0, 1'b1};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // operator at the very start, every operator, value extremes
        add_tok(K_PLUS, $urandom());
        add_tok(K_NUM, '0);
        add_tok(TK_MINUS, $urandom());
        add_tok(K_NUM, '1);
        add_tok(TK_TIMES, $urandom());
        add_tok(K_NUM, 32'h0000_0001);
        add_tok(TK_DIV, $urandom());
        add_tok(K_NUM, 32'hA5A5_A5A5);
        add_tok(K_POW, $urandom());
        add_tok(K_NUM, 32'h5A5A_5A5A);
        add_tok(K_END, $urandom());
        // implicit * after an operand and after ')'
        add_tok(K_NUM, 32'd7);
        add_tok(K_OPEN, $urandom());
        add_tok(K_NUM, 32'h8000_0000);
        add_tok(K_CLOSE, $urandom());
        add_tok(K_OPEN, $urandom());
        add_tok(K_NUM, 32'h7FFF_FFFF);
        add_tok(K_CLOSE, $urandom());
        add_tok(K_END, $urandom());
        // unmatched ')', unclosed '(', ignored kind
        add_tok(K_NUM, 32'd3);
        add_tok(K_CLOSE, $urandom());
        add_tok(K_OPEN, $urandom());
        add_tok(TK_LAST, $urandom());
        add_tok(K_END, $urandom());
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            write_reg(int'(REG_IMUL_IDX), {31'($urandom()), phase_imul[p]});
            imul_en   = phase_imul[p];
            send_pct  = phase_send[p];
            stall_pct = phase_stall[p];
            if (p == 0) begin
                hold_req = 1'b1;  // long output hold-off to back up the stack
                add_deep_nest();
            end
            goal = stim_items + PHASE_ITEMS;
            while (stim_items < goal) add_sentence();
            wait_drained();
        end

        $display("Run covered %0d tokens over four idling settings, implicit * on and off.",
                 tokens_in);
        $display("Checked %0d postfix words, %0d end markers (%0d overflow, %0d unmatched).",
                 words_seen, end_words, ovf_ends, unm_ends);
        if (mismatches == 0) begin
            $display("[infix_to_postfix_converter_top] OK");
        end else begin
            $display("[infix_to_postfix_converter_top] ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // token driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                convert_token(i_in_data);
                tokens_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (token_q.size() > 0 && !take_gap(send_pct)) begin
                    i_in_data  <= token_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall: one long hold-off on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= take_gap(stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // postfix monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (postfix_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d value %0h",
                                          o_out_data.out_kind, o_out_data.out_value));
            end else begin
                want = postfix_q.pop_front();
                check_field("kind", VAL_W'(o_out_data.out_kind), VAL_W'(want.out_kind));
                check_field("value", o_out_data.out_value, want.out_value);
                check_field("last", VAL_W'(o_out_data.out_last), VAL_W'(want.out_last));
                check_field("error", VAL_W'(o_out_data.out_error), VAL_W'(want.out_error));
                words_seen++;
                if (want.out_kind == OUT_END) begin
                    end_words++;
                    if (want.out_error == ERR_OVERFLOW) ovf_ends++;
                    if (want.out_error == ERR_UNMATCHED) unm_ends++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("[infix_to_postfix_converter_top] ERROR");
            $finish;
        end
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_cell.sv
rtl/itp_stack.sv
rtl/infix_to_postfix_converter_top.sv
rtl/itp_checker.sv
test/tb_top.sv
